FILE: rtl/assert_macros.svh
// Assertion helpers for the ranger's modules; only erm_back uses them.
// Each use expects signals named clock and reset in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock, ignored while reset is high
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error(msg);

// Check that a condition in one cycle implies another in the next cycle
`define ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

FILE: rtl/erm_pkg.sv
`default_nettype none

package erm_pkg;

   // Field widths
   localparam int SCALE_W     = 16;
   localparam int DIST_W      = 16;
   localparam int DIGIT_W     = 4;
   localparam int BYTE_W      = 8;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   // Parameter defaults
   localparam int COUNT_WIDTH_DEF     = 16;
   localparam int MAX_FRAME_BYTES_DEF = 20;

   // Depth of the queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Digit split: values up to the display limit, reciprocal multiply
   localparam int DIGIT_LIMIT = 999;
   localparam int DISP_W      = 10;
   localparam int HUND        = 100;
   localparam int TEN         = 10;
   localparam int HUND_RECIP  = 41;
   localparam int HUND_SHIFT  = 12;
   localparam int HPROD_W     = 16;
   localparam int REM_W       = 7;
   localparam int TEN_RECIP   = 205;
   localparam int TEN_SHIFT   = 11;
   localparam int TPROD_W     = 15;

   // Register reset values
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd151;
   localparam logic [DIST_W-1:0]  FAR_RESET   = 16'd200;
   localparam logic [DIST_W-1:0]  NEAR_RESET  = 16'd100;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCALE = 2'd0,
      CSR_MODE  = 2'd1,
      CSR_FAR   = 2'd2,
      CSR_NEAR  = 2'd3
   } csr_index_type;

   typedef enum logic [1:0] {
      MODE_NONE   = 2'd0,
      MODE_FAR    = 2'd1,
      MODE_MIDDLE = 2'd2,
      MODE_NEAR   = 2'd3
   } alert_mode_type;

   typedef enum logic [1:0] {
      SEL_FAR    = 2'd0,
      SEL_MIDDLE = 2'd1,
      SEL_NEAR   = 2'd2
   } alert_sel_type;

   typedef struct packed {
      logic [SCALE_W-1:0] scale_q16;
      alert_mode_type     alert_mode;
      logic [DIST_W-1:0]  far_threshold;
      logic [DIST_W-1:0]  near_threshold;
   } cfg_type;

   // Voice frame ROM
   localparam int ROM_SLOTS   = 20;
   localparam int ROM_IDX_W   = 5;
   localparam int FRAME_LEN_W = 6;
   localparam logic [FRAME_LEN_W-1:0] FAR_LEN    = 6'd20;
   localparam logic [FRAME_LEN_W-1:0] MIDDLE_LEN = 6'd20;
   localparam logic [FRAME_LEN_W-1:0] NEAR_LEN   = 6'd14;

   localparam logic [BYTE_W-1:0] FAR_FRAME [ROM_SLOTS] = '{
      8'hFD, 8'h00, 8'h11, 8'h01, 8'h01, 8'h73, 8'h6F, 8'h75, 8'h6E, 8'h64,
      8'h6B, 8'hB4, 8'hF3, 8'hD3, 8'hDA, 8'hC1, 8'hBD, 8'hC3, 8'hD7, 8'hC2
   };
   localparam logic [BYTE_W-1:0] MIDDLE_FRAME [ROM_SLOTS] = '{
      8'hFD, 8'h00, 8'h11, 8'h01, 8'h01, 8'h73, 8'h6F, 8'h75, 8'h6E, 8'h64,
      8'h6B, 8'hB4, 8'hF3, 8'hD3, 8'hDA, 8'hD2, 8'hBB, 8'hC3, 8'hD7, 8'hD7
   };
   localparam logic [BYTE_W-1:0] NEAR_FRAME [ROM_SLOTS] = '{
      8'hFD, 8'h00, 8'h0B, 8'h01, 8'h01, 8'hD0, 8'hA1, 8'hD3, 8'hDA, 8'hD2,
      8'hBB, 8'hC3, 8'hD7, 8'hF3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
   };

   function automatic logic [BYTE_W-1:0] frame_byte(alert_sel_type sel,
                                                     logic [ROM_IDX_W-1:0] idx);
      logic [BYTE_W-1:0] b;
      b = '0;
      if (idx < ROM_IDX_W'(ROM_SLOTS)) begin
         unique case (sel)
            SEL_FAR:    b = FAR_FRAME[idx];
            SEL_MIDDLE: b = MIDDLE_FRAME[idx];
            SEL_NEAR:   b = NEAR_FRAME[idx];
            default:    b = '0;
         endcase
      end
      return b;
   endfunction

   function automatic logic [FRAME_LEN_W-1:0] frame_len(alert_sel_type sel);
      logic [FRAME_LEN_W-1:0] n;
      unique case (sel)
         SEL_FAR:    n = FAR_LEN;
         SEL_MIDDLE: n = MIDDLE_LEN;
         SEL_NEAR:   n = NEAR_LEN;
         default:    n = '0;
      endcase
      return n;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/erm_req_if.sv
`default_nettype none

interface erm_req_if;
   logic valid;
   logic ready;
   logic echo_level;

   modport source (output valid, output echo_level, input ready);
   modport sink   (input valid, input echo_level, output ready);
endinterface

`default_nettype wire

FILE: rtl/erm_rsp_if.sv
`default_nettype none

interface erm_rsp_if;
   import erm_pkg::*;

   logic                valid;
   logic                ready;
   logic [DIST_W-1:0]   distance_cm;
   logic [DIGIT_W-1:0]  hundreds_digit;
   logic [DIGIT_W-1:0]  tens_digit;
   logic [DIGIT_W-1:0]  units_digit;
   logic [BYTE_W-1:0]   alert_byte;
   logic                alert_valid;
   logic                last;

   modport source (output valid, output distance_cm, output hundreds_digit,
                   output tens_digit, output units_digit, output alert_byte,
                   output alert_valid, output last, input ready);
   modport sink   (input valid, input distance_cm, input hundreds_digit,
                   input tens_digit, input units_digit, input alert_byte,
                   input alert_valid, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/erm_front.sv
`default_nettype none

module erm_front #(
   parameter int COUNT_WIDTH = erm_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   erm_req_if.sink                     req,
   input  wire logic                   q_full,
   output logic                        q_push,
   output logic [COUNT_WIDTH-1:0]      q_count
);
   import erm_pkg::*;

   logic                   echo_active_ff, echo_active_in;
   logic [COUNT_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic                   accept;

   // Take a request whenever the queue has room
   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;

   // Count high ticks, hand the count over on the falling tick
   always_comb begin
      echo_active_in = echo_active_ff;
      tick_count_in  = tick_count_ff;
      q_push         = 1'b0;
      if (accept) begin
         if (req.echo_level) begin
            echo_active_in = 1'b1;
            if (tick_count_ff != '1) begin
               tick_count_in = tick_count_ff + 1'b1;
            end
         end else if (echo_active_ff) begin
            q_push         = 1'b1;
            echo_active_in = 1'b0;
            tick_count_in  = '0;
         end
      end
   end

   assign q_count = tick_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_active_ff <= 1'b0;
         tick_count_ff  <= '0;
      end else begin
         echo_active_ff <= echo_active_in;
         tick_count_ff  <= tick_count_in;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/erm_queue.sv
`default_nettype none

module erm_queue #(
   parameter int WIDTH = erm_pkg::COUNT_WIDTH_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   output logic                  pop_valid,
   output logic [WIDTH-1:0]      pop_data,
   input  wire logic             pop
);
   import erm_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic             do_pop;

   assign full      = (fill_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (fill_ff != '0);
   assign pop_data  = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   // Advance the pointers and the fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the pushed count
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/erm_back.sv
`default_nettype none
`include "assert_macros.svh"

module erm_back #(
   parameter int COUNT_WIDTH     = erm_pkg::COUNT_WIDTH_DEF,
   parameter int MAX_FRAME_BYTES = erm_pkg::MAX_FRAME_BYTES_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire erm_pkg::cfg_type       cfg,
   input  wire logic                   q_valid,
   input  wire logic [COUNT_WIDTH-1:0] q_count,
   output logic                        q_pop,
   erm_rsp_if.source                   rsp
);
   import erm_pkg::*;

   localparam int PROD_W = COUNT_WIDTH + SCALE_W;
   localparam int IDX_W  = $clog2(MAX_FRAME_BYTES);

   // ---------------- stage 1: scale to centimetres ----------------
   logic [PROD_W-1:0]      prod;
   logic [COUNT_WIDTH-1:0] prod_hi;
   logic [DIST_W-1:0]      mul_dist;
   logic                   s1_valid_ff, s1_valid_in;
   logic [DIST_W-1:0]      s1_dist_ff, s1_dist_in;
   logic                   s1_load;

   assign prod    = PROD_W'(q_count) * PROD_W'(cfg.scale_q16);
   assign prod_hi = prod[PROD_W-1:SCALE_W];

   // Saturate when the count is wider than the distance field
   generate
      if (COUNT_WIDTH > DIST_W) begin : g_sat
         assign mul_dist = (|prod_hi[COUNT_WIDTH-1:DIST_W]) ? '1 : prod_hi[DIST_W-1:0];
      end else begin : g_nosat
         assign mul_dist = DIST_W'(prod_hi);
      end
   endgenerate

   // ---------------- stage 2: digits, alert choice, frame walk ----------------
   logic [DISP_W-1:0]      shown;
   logic [HPROD_W-1:0]     h_prod;
   logic [DIGIT_W-1:0]     h_dig;
   logic [DISP_W-1:0]      hund_part;
   logic [REM_W-1:0]       rem;
   logic [TPROD_W-1:0]     t_prod;
   logic [DIGIT_W-1:0]     t_dig;
   logic [DIGIT_W-1:0]     u_dig;
   logic                   alert_c;
   alert_sel_type          sel_c;
   logic [FRAME_LEN_W-1:0] flen;
   logic [FRAME_LEN_W-1:0] lim;

   logic                   rec_valid_ff, rec_valid_in;
   logic [DIST_W-1:0]      rec_dist_ff, rec_dist_in;
   logic [DIGIT_W-1:0]     rec_hund_ff, rec_hund_in;
   logic [DIGIT_W-1:0]     rec_tens_ff, rec_tens_in;
   logic [DIGIT_W-1:0]     rec_units_ff, rec_units_in;
   logic                   rec_alert_ff, rec_alert_in;
   alert_sel_type          rec_sel_ff, rec_sel_in;
   logic [IDX_W-1:0]       rec_last_ff, rec_last_in;
   logic [IDX_W-1:0]       rec_idx_ff, rec_idx_in;

   logic                   emit;
   logic                   is_last;
   logic                   rec_take;

   // Split the shown distance with reciprocal multiplies
   always_comb begin
      shown     = (s1_dist_ff > DIST_W'(DIGIT_LIMIT)) ? '0 : s1_dist_ff[DISP_W-1:0];
      h_prod    = HPROD_W'(shown) * HPROD_W'(HUND_RECIP);
      h_dig     = h_prod[HUND_SHIFT +: DIGIT_W];
      hund_part = DISP_W'(h_dig) * DISP_W'(HUND);
      rem       = REM_W'(shown - hund_part);
      t_prod    = TPROD_W'(rem) * TPROD_W'(TEN_RECIP);
      t_dig     = t_prod[TEN_SHIFT +: DIGIT_W];
      u_dig     = DIGIT_W'(rem - REM_W'(REM_W'(t_dig) * REM_W'(TEN)));
   end

   // Choose the alert frame from the mode and the thresholds
   always_comb begin
      alert_c = 1'b0;
      sel_c   = SEL_FAR;
      unique case (cfg.alert_mode)
         MODE_NONE: begin
            alert_c = 1'b0;
         end
         MODE_FAR: begin
            alert_c = (s1_dist_ff > cfg.far_threshold);
            sel_c   = SEL_FAR;
         end
         MODE_MIDDLE: begin
            alert_c = (s1_dist_ff <= cfg.far_threshold) &&
                      (s1_dist_ff >= cfg.near_threshold);
            sel_c   = SEL_MIDDLE;
         end
         MODE_NEAR: begin
            alert_c = (s1_dist_ff <= cfg.near_threshold);
            sel_c   = SEL_NEAR;
         end
         default: begin
            alert_c = 1'b0;
         end
      endcase
      flen = frame_len(sel_c);
      lim  = (flen > FRAME_LEN_W'(MAX_FRAME_BYTES)) ? FRAME_LEN_W'(MAX_FRAME_BYTES) : flen;
   end

   // Hand shaking between the stages and the output register
   assign emit     = rec_valid_ff && (!rsp.valid || rsp.ready);
   assign is_last  = !rec_alert_ff || (rec_idx_ff == rec_last_ff);
   assign rec_take = !rec_valid_ff || (emit && is_last);
   assign s1_load  = q_valid && (!s1_valid_ff || rec_take);
   assign q_pop    = s1_load;

   // Advance stage 1
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_dist_in  = s1_dist_ff;
      if (s1_load) begin
         s1_valid_in = 1'b1;
         s1_dist_in  = mul_dist;
      end else if (rec_take) begin
         s1_valid_in = 1'b0;
      end
   end

   // Load a new record or step through the frame
   always_comb begin
      rec_valid_in = rec_valid_ff;
      rec_dist_in  = rec_dist_ff;
      rec_hund_in  = rec_hund_ff;
      rec_tens_in  = rec_tens_ff;
      rec_units_in = rec_units_ff;
      rec_alert_in = rec_alert_ff;
      rec_sel_in   = rec_sel_ff;
      rec_last_in  = rec_last_ff;
      rec_idx_in   = rec_idx_ff;
      if (rec_take) begin
         rec_valid_in = s1_valid_ff;
         rec_dist_in  = s1_dist_ff;
         rec_hund_in  = h_dig;
         rec_tens_in  = t_dig;
         rec_units_in = u_dig;
         rec_alert_in = alert_c;
         rec_sel_in   = sel_c;
         rec_last_in  = IDX_W'(lim - FRAME_LEN_W'(1));
         rec_idx_in   = '0;
      end else if (emit) begin
         rec_idx_in = rec_idx_ff + 1'b1;
      end
   end

   // ---------------- output register ----------------
   logic               rsp_valid_ff, rsp_valid_in;
   logic [DIST_W-1:0]  out_dist_ff, out_dist_in;
   logic [DIGIT_W-1:0] out_hund_ff, out_hund_in;
   logic [DIGIT_W-1:0] out_tens_ff, out_tens_in;
   logic [DIGIT_W-1:0] out_units_ff, out_units_in;
   logic [BYTE_W-1:0]  out_byte_ff, out_byte_in;
   logic               out_alert_ff, out_alert_in;
   logic               out_last_ff, out_last_in;

   // Hold the result until it is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      out_dist_in  = out_dist_ff;
      out_hund_in  = out_hund_ff;
      out_tens_in  = out_tens_ff;
      out_units_in = out_units_ff;
      out_byte_in  = out_byte_ff;
      out_alert_in = out_alert_ff;
      out_last_in  = out_last_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         out_dist_in  = rec_dist_ff;
         out_hund_in  = rec_hund_ff;
         out_tens_in  = rec_tens_ff;
         out_units_in = rec_units_ff;
         out_byte_in  = rec_alert_ff ? frame_byte(rec_sel_ff, ROM_IDX_W'(rec_idx_ff)) : '0;
         out_alert_in = rec_alert_ff;
         out_last_in  = is_last;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.distance_cm    = out_dist_ff;
   assign rsp.hundreds_digit = out_hund_ff;
   assign rsp.tens_digit     = out_tens_ff;
   assign rsp.units_digit    = out_units_ff;
   assign rsp.alert_byte     = out_byte_ff;
   assign rsp.alert_valid    = out_alert_ff;
   assign rsp.last           = out_last_ff;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rec_valid_ff <= 1'b0;
         rec_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rec_valid_ff <= rec_valid_in;
         rec_idx_ff   <= rec_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      s1_dist_ff   <= s1_dist_in;
      rec_dist_ff  <= rec_dist_in;
      rec_hund_ff  <= rec_hund_in;
      rec_tens_ff  <= rec_tens_in;
      rec_units_ff <= rec_units_in;
      rec_alert_ff <= rec_alert_in;
      rec_sel_ff   <= rec_sel_in;
      rec_last_ff  <= rec_last_in;
      out_dist_ff  <= out_dist_in;
      out_hund_ff  <= out_hund_in;
      out_tens_ff  <= out_tens_in;
      out_units_ff <= out_units_in;
      out_byte_ff  <= out_byte_in;
      out_alert_ff <= out_alert_in;
      out_last_ff  <= out_last_in;
   end

   // ---------------- checks ----------------
   `ASSERT_CLK(a_idx_in_frame, !rec_valid_ff || !rec_alert_ff || (rec_idx_ff <= rec_last_ff), "frame index ran past the final byte")
   `ASSERT_CLK(a_digits_decimal, !rec_valid_ff || ((rec_hund_ff <= DIGIT_W'(9)) && (rec_tens_ff <= DIGIT_W'(9)) && (rec_units_ff <= DIGIT_W'(9))), "digit split gave a non-decimal digit")
   `ASSERT_NEXT(a_s1_holds, s1_valid_ff && !rec_take, s1_valid_ff && $stable(s1_dist_ff), "stage 1 lost its distance while stalled")
   `ASSERT_NEXT(a_rec_holds, emit && !is_last, rec_valid_ff, "record dropped before its final byte")

endmodule

`default_nettype wire

FILE: rtl/echo_range_meter_with_alert.sv
// Echo range meter with voice alert.
// req_chan carries one timer tick per request, with the sampled echo level.
// While the echo is high the tick count grows (saturating); the first low
// tick after a high stretch closes the measurement. rsp_chan then gives one
// result per byte of the selected alert frame (last on the final byte), or a
// single result with alert_valid low when no alert applies. Distance and
// digits repeat in every result of one measurement.
// Throughput: one request per cycle, and one result per cycle while the
// receiver is ready. Requests are taken every cycle while the four-entry
// measurement queue has room; a long frame or a stalled receiver fills it,
// and req_chan.ready then drops. The first result of a measurement passes
// through the queue, the multiply stage, the frame stage and the output
// register, and waits longer when earlier frames are still being sent.
// Reset (synchronous, high) empties the queue and the pipeline, clears the
// tick counter and sets the registers to their defaults. A stalled receiver
// holds the current result in the output register; nothing is dropped.
// csr_we writes csr_wdata to register csr_index; the user must write only while the block is idle (unenforced).
`default_nettype none

module echo_range_meter_with_alert #(
   parameter int COUNT_WIDTH     = erm_pkg::COUNT_WIDTH_DEF,
   parameter int MAX_FRAME_BYTES = erm_pkg::MAX_FRAME_BYTES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   erm_req_if.sink                                req_chan,
   erm_rsp_if.source                              rsp_chan,
   input  wire logic                              csr_we,
   input  wire logic [erm_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [erm_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import erm_pkg::*;

   cfg_type                cfg_ff, cfg_in;
   logic                   q_push;
   logic [COUNT_WIDTH-1:0] q_push_count;
   logic                   q_full;
   logic                   q_valid;
   logic [COUNT_WIDTH-1:0] q_count;
   logic                   q_pop;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_SCALE: cfg_in.scale_q16      = csr_wdata[SCALE_W-1:0];
            CSR_MODE:  cfg_in.alert_mode     = alert_mode_type'(csr_wdata[1:0]);
            CSR_FAR:   cfg_in.far_threshold  = csr_wdata[DIST_W-1:0];
            CSR_NEAR:  cfg_in.near_threshold = csr_wdata[DIST_W-1:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.scale_q16      <= SCALE_RESET;
         cfg_ff.alert_mode     <= MODE_NONE;
         cfg_ff.far_threshold  <= FAR_RESET;
         cfg_ff.near_threshold <= NEAR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   erm_front #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_chan),
      .q_full  (q_full),
      .q_push  (q_push),
      .q_count (q_push_count)
   );

   erm_queue #(
      .WIDTH (COUNT_WIDTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_count),
      .full      (q_full),
      .pop_valid (q_valid),
      .pop_data  (q_count),
      .pop       (q_pop)
   );

   erm_back #(
      .COUNT_WIDTH     (COUNT_WIDTH),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_count (q_count),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: sim/range_reading_checker.sv
`timescale 1ns / 100ps

module range_reading_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   erm_req_if                                   req_chan,
   erm_rsp_if                                   rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [erm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [erm_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                                   error_count,
   output int                                   readings_due,
   output int                                   measurements_closed,
   output int                                   frames_sent
);
   import erm_pkg::*;

   localparam int COUNT_W   = COUNT_WIDTH_DEF;
   localparam int FRAME_CAP = MAX_FRAME_BYTES_DEF;
   localparam int REPORT_CAP = 40;

   typedef struct packed {
      logic [DIST_W-1:0]  distance_cm;
      logic [DIGIT_W-1:0] hundreds;
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] units;
      logic [BYTE_W-1:0]  alert_byte;
      logic               alert_valid;
      logic               last;
   } range_reading_type;

   range_reading_type  readings_q[$];

   // Shadow of the ranger's registers and measurement state
   logic [SCALE_W-1:0] scale;
   alert_mode_type     mode;
   logic [DIST_W-1:0]  far_cm;
   logic [DIST_W-1:0]  near_cm;
   logic               echo_high;
   logic [COUNT_W-1:0] ticks;

   int mismatch_total = 0;
   int closed_total   = 0;
   int frame_total    = 0;

   assign error_count         = mismatch_total;
   assign measurements_closed = closed_total;
   assign frames_sent         = frame_total;

   task automatic report_mismatch(string msg);
      if (mismatch_total < REPORT_CAP) begin
         $display("[%0t] mismatch: %s", $realtime, msg);
      end
      mismatch_total++;
   endtask

   task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s is %0h, should be %0h", name, got, want));
      end
   endtask

   // Count high ticks; on the closing low tick, queue the readings it causes
   task automatic predict_echo_tick(logic level);
      logic [47:0]       product;
      logic [DIST_W-1:0] dist_cm;
      logic [DIST_W-1:0] shown;
      alert_sel_type     sel;
      bit                alerting;
      int                n;
      range_reading_type r;
      if (level) begin
         echo_high = 1'b1;
         if (ticks != '1) begin
            ticks++;
         end
      end else if (echo_high) begin
         product = (48'(ticks) * 48'(scale)) >> 16;
         dist_cm = (product > 48'hFFFF) ? '1 : product[DIST_W-1:0];
         shown   = (dist_cm > DIGIT_LIMIT) ? '0 : dist_cm;
         r.distance_cm = dist_cm;
         r.hundreds    = DIGIT_W'(shown / 100);
         r.tens        = DIGIT_W'((shown % 100) / 10);
         r.units       = DIGIT_W'(shown % 10);

         // pick the frame from mode and thresholds
         alerting = 1'b0;
         sel      = SEL_FAR;
         case (mode)
            MODE_FAR: begin
               if (dist_cm > far_cm) begin
                  alerting = 1'b1;
                  sel      = SEL_FAR;
               end
            end
            MODE_MIDDLE: begin
               if (dist_cm <= far_cm && dist_cm >= near_cm) begin
                  alerting = 1'b1;
                  sel      = SEL_MIDDLE;
               end
            end
            MODE_NEAR: begin
               if (dist_cm <= near_cm) begin
                  alerting = 1'b1;
                  sel      = SEL_NEAR;
               end
            end
            default: ;
         endcase

         echo_high = 1'b0;
         ticks     = '0;
         closed_total++;

         n = 0;
         if (alerting) begin
            case (sel)
               SEL_FAR:    n = int'(FAR_LEN);
               SEL_MIDDLE: n = int'(MIDDLE_LEN);
               default:    n = int'(NEAR_LEN);
            endcase
            if (n > FRAME_CAP) begin
               n = FRAME_CAP;
            end
         end

         if (n == 0) begin
            r.alert_byte  = '0;
            r.alert_valid = 1'b0;
            r.last        = 1'b1;
            readings_q.push_back(r);
         end else begin
            for (int k = 0; k < n; k++) begin
               case (sel)
                  SEL_FAR:    r.alert_byte = FAR_FRAME[k];
                  SEL_MIDDLE: r.alert_byte = MIDDLE_FRAME[k];
                  default:    r.alert_byte = NEAR_FRAME[k];
               endcase
               r.alert_valid = 1'b1;
               r.last        = (k == n - 1);
               readings_q.push_back(r);
            end
         end
      end
   endtask

   always @(posedge clock) begin : watch
      range_reading_type want;
      if (reset) begin
         scale     = SCALE_RESET;
         mode      = MODE_NONE;
         far_cm    = FAR_RESET;
         near_cm   = NEAR_RESET;
         echo_high = 1'b0;
         ticks     = '0;
         readings_q.delete();
      end else begin
         // track register writes; bits above a register's width drop out
         if (csr_we) begin
            case (csr_index)
               CSR_SCALE: scale   = csr_wdata[SCALE_W-1:0];
               CSR_MODE:  mode    = alert_mode_type'(csr_wdata[1:0]);
               CSR_FAR:   far_cm  = csr_wdata[DIST_W-1:0];
               CSR_NEAR:  near_cm = csr_wdata[DIST_W-1:0];
               default: ;
            endcase
         end

         // compare each accepted result with the oldest reading due
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (readings_q.size() == 0) begin
               report_mismatch($sformatf("unexpected result, distance %0d byte %0h",
                                         rsp_chan.distance_cm, rsp_chan.alert_byte));
            end else begin
               want = readings_q.pop_front();
               check_field("distance_cm", rsp_chan.distance_cm, want.distance_cm);
               check_field("hundreds_digit", rsp_chan.hundreds_digit, want.hundreds);
               check_field("tens_digit", rsp_chan.tens_digit, want.tens);
               check_field("units_digit", rsp_chan.units_digit, want.units);
               check_field("alert_byte", rsp_chan.alert_byte, want.alert_byte);
               check_field("alert_valid", rsp_chan.alert_valid, want.alert_valid);
               check_field("last", rsp_chan.last, want.last);
               if (want.alert_valid && want.last) begin
                  frame_total++;
               end
            end
         end

         if (req_chan.valid && req_chan.ready) begin
            predict_echo_tick(req_chan.echo_level);
         end
      end
      readings_due <= readings_q.size();
   end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
   import erm_pkg::*;

   localparam int CYCLE_LIMIT       = 600_000;
   localparam int TICKS_PER_PHASE   = 30;
   localparam int SETTLE_CYCLES     = 8;
   localparam int DIGIT_PULSE_MIN   = 101;
   localparam int DIGIT_PULSE_MAX   = 140;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int sender_idle_pct   = 35;
   int receiver_idle_pct = 46;
   int cycle_count       = 0;
   int ticks_sent        = 0;

   int error_count;
   int readings_due;
   int measurements_closed;
   int frames_sent;

   erm_req_if req_chan ();
   erm_rsp_if rsp_chan ();

   echo_range_meter_with_alert i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   range_reading_checker i_checker (
      .clock               (clock),
      .reset               (reset),
      .req_chan            (req_chan),
      .rsp_chan            (rsp_chan),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .error_count         (error_count),
      .readings_due        (readings_due),
      .measurements_closed (measurements_closed),
      .frames_sent         (frames_sent)
   );

   always #5 clock = ~clock;

   // Stall the result channel at random
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= receiver_idle_pct);
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d readings still due",
                  cycle_count, readings_due);
         $display("testbench: FAIL");
         $finish;
      end
   end

   // Offer one tick request, idling first at random, and hold it until taken
   task automatic send_tick(logic level);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid      <= 1'b0;
         req_chan.echo_level <= 1'($urandom);
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.echo_level <= level;
      do @(posedge clock); while (!req_chan.ready);
      ticks_sent++;
   endtask

   // Low ticks while idle, a high stretch, then the closing low tick
   task automatic send_echo_pulse(int n_high, int n_idle_low);
      repeat (n_idle_low) send_tick(1'b0);
      repeat (n_high) send_tick(1'b1);
      send_tick(1'b0);
   endtask

   // Hold requests until every reading has come out and the pipeline is empty
   task automatic drain_readings();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (readings_due != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write all four registers once the block is idle
   task automatic program_ranger(logic [SCALE_W-1:0] scale, alert_mode_type mode,
                                 logic [DIST_W-1:0] far_cm, logic [DIST_W-1:0] near_cm);
      drain_readings();
      csr_we    <= 1'b1;
      csr_index <= CSR_SCALE;
      csr_wdata <= scale;
      @(posedge clock);
      csr_index <= CSR_MODE;
      csr_wdata <= {14'($urandom), mode};
      @(posedge clock);
      csr_index <= CSR_FAR;
      csr_wdata <= far_cm;
      @(posedge clock);
      csr_index <= CSR_NEAR;
      csr_wdata <= near_cm;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic pick_random_settings();
      logic [SCALE_W-1:0] scale;
      logic [DIST_W-1:0]  far_cm;
      logic [DIST_W-1:0]  near_cm;
      case ($urandom_range(9))
         0:       scale = '0;
         1:       scale = '1;
         2:       scale = SCALE_RESET;
         default: scale = SCALE_W'($urandom_range(16384, 65535));
      endcase
      case ($urandom_range(9))
         0:       far_cm = '0;
         1:       far_cm = '1;
         default: far_cm = DIST_W'($urandom_range(0, 12));
      endcase
      case ($urandom_range(9))
         0:       near_cm = '0;
         1:       near_cm = '1;
         default: near_cm = DIST_W'($urandom_range(0, 12));
      endcase
      program_ranger(scale, alert_mode_type'($urandom_range(3)), far_cm, near_cm);
   endtask

   // Short pulses under changing settings
   task automatic run_random_phase(int s_idle, int r_idle);
      int ticks_in_phase;
      int pulses;
      int n_high;
      sender_idle_pct   = s_idle;
      receiver_idle_pct = r_idle;
      ticks_in_phase    = 0;
      pulses            = 0;
      pick_random_settings();
      while (ticks_in_phase < TICKS_PER_PHASE) begin
         if (pulses % 6 == 5) begin
            pick_random_settings();
         end
         n_high = $urandom_range(1, 10);
         send_echo_pulse(n_high, ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0);
         ticks_in_phase += n_high + 1;
         pulses++;
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.echo_level <= 1'b0;
      csr_we              <= 1'b0;
      csr_index           <= CSR_SCALE;
      csr_wdata           <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: reset settings with an ignored idle low tick first
      send_echo_pulse(1, 1);
      // each alert frame, then thresholds that exclude the distance
      program_ranger('1, MODE_FAR, 16'd2, 16'd1);
      send_echo_pulse(5, 0);
      program_ranger('1, MODE_MIDDLE, 16'd2, 16'd1);
      send_echo_pulse(3, 0);
      program_ranger('1, MODE_NEAR, 16'd2, 16'd1);
      send_echo_pulse(2, 0);
      program_ranger('1, MODE_NEAR, '1, '0);
      send_echo_pulse(2, 0);
      // crossed thresholds shut out the middle frame
      program_ranger('1, MODE_MIDDLE, 16'd2, 16'd5);
      send_echo_pulse(4, 0);
      program_ranger('0, MODE_FAR, '0, '1);
      send_echo_pulse(2, 0);

      run_random_phase(35, 46);
      run_random_phase(46, 35);
      run_random_phase(0, 0);

      // One long pulse for a three-digit reading inside the middle band
      program_ranger('1, MODE_MIDDLE, 16'd150, 16'd100);
      send_echo_pulse($urandom_range(DIGIT_PULSE_MIN, DIGIT_PULSE_MAX), 0);

      drain_readings();
      repeat (16) @(posedge clock);

      $display("covered %0d measurements from %0d tick requests, %0d alert frames sent",
               measurements_closed, ticks_sent, frames_sent);
      $display("stall profiles: sender-heavy, receiver-heavy, none; one three-digit reading");
      if (error_count == 0 && readings_due == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/erm_pkg.sv
rtl/erm_req_if.sv
rtl/erm_rsp_if.sv
rtl/erm_front.sv
rtl/erm_queue.sv
rtl/erm_back.sv
rtl/echo_range_meter_with_alert.sv
sim/range_reading_checker.sv
sim/testbench.sv
